/* hw/rtl/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// Link failover supervisor package
// Shared types, codes and reset values for the supervisor core and its
// step logic.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Supervisor modes as carried on the result mode field.
  localparam logic [1:0] MODE_CONNECTING = 2'd0;
  localparam logic [1:0] MODE_ACTIVE     = 2'd1;
  localparam logic [1:0] MODE_GRACE      = 2'd2;
  localparam logic [1:0] MODE_BACKUP     = 2'd3;

  // Long-range message codes.
  localparam logic [1:0] MSG_NONE     = 2'd0;
  localparam logic [1:0] MSG_MISSING  = 2'd1;
  localparam logic [1:0] MSG_RETURNED = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_PERIOD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_WAIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_RETRY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 3'd5;

  // Configuration reset values in milliseconds.
  localparam logic [31:0] OFF_PERIOD_RST    = 32'd120000;
  localparam logic [31:0] ON_PERIOD_RST     = 32'd40000;
  localparam logic [31:0] CONNECT_WAIT_RST  = 32'd5000;
  localparam logic [31:0] GRACE_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] JOIN_RETRY_RST    = 32'd30000;
  localparam logic [31:0] SEND_INTERVAL_RST = 32'd60000;

  // One supervisory step request.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        gateway_connected;
    logic        join_ok;
  } step_t;

  // One result of a step.
  typedef struct packed {
    logic [1:0] mode;
    logic       radio_on;
    logic       radio_start;
    logic       radio_stop;
    logic       join_request;
    logic [1:0] message;
  } result_t;

  // Timing configuration.
  typedef struct packed {
    logic [31:0] off_period_ms;
    logic [31:0] on_period_ms;
    logic [31:0] connect_wait_ms;
    logic [31:0] grace_time_ms;
    logic [31:0] join_spacing_ms;
    logic [31:0] send_interval_ms;
  } cfg_t;

  // Supervisor state carried from one step to the next.
  typedef struct packed {
    logic [1:0]  fsm_mode;
    logic        phase_on;
    logic [31:0] phase_start_time;
    logic [31:0] wait_start_time;
    logic [31:0] grace_start_time;
    logic [31:0] last_send_time;
    logic [31:0] last_join_time;
    logic        joined;
  } state_t;

endpackage

/* hw/rtl/lfs_step.sv */
// ----------------------------------------------------------------------------
// Link failover supervisor step logic
// Combinational next-state and result logic for one supervisory step: the
// radio duty cycle first, then the four-mode link state machine.
// ----------------------------------------------------------------------------
module lfs_step (
  input  lfs_pkg::state_t  state,
  input  lfs_pkg::cfg_t    cfg,
  input  lfs_pkg::step_t   step,
  output lfs_pkg::state_t  state_next,
  output lfs_pkg::result_t result
);

  logic [31:0] phase_elapsed;
  logic [31:0] wait_elapsed;
  logic [31:0] grace_elapsed;
  logic [31:0] send_elapsed;
  logic [31:0] join_elapsed;
  logic        turn_on;
  logic        turn_off;
  logic        link_ok;
  logic        joined_now;
  lfs_pkg::state_t mid;

  // All elapsed times use wrapping subtraction, computed side by side.
  assign phase_elapsed = step.now_ms - state.phase_start_time;
  assign grace_elapsed = step.now_ms - state.grace_start_time;
  assign send_elapsed  = step.now_ms - state.last_send_time;
  assign join_elapsed  = step.now_ms - state.last_join_time;
  // A turn-on restarts the connect-wait timer at this very step.
  assign wait_elapsed  = turn_on ? 32'd0 : (step.now_ms - state.wait_start_time);

  assign turn_on  = !state.phase_on && (phase_elapsed >= cfg.off_period_ms);
  assign turn_off =  state.phase_on && (phase_elapsed >= cfg.on_period_ms);

  always_comb begin
    // Duty cycle phase change forces the mode back to connecting.
    mid = state;
    if (turn_on) begin
      mid.phase_on         = 1'b1;
      mid.phase_start_time = step.now_ms;
      mid.wait_start_time  = step.now_ms;
      mid.fsm_mode         = lfs_pkg::MODE_CONNECTING;
    end else if (turn_off) begin
      mid.phase_on         = 1'b0;
      mid.phase_start_time = step.now_ms;
      mid.fsm_mode         = lfs_pkg::MODE_CONNECTING;
    end

    link_ok    = step.gateway_connected && mid.phase_on;
    joined_now = mid.joined;

    state_next          = mid;
    result.radio_start  = turn_on;
    result.radio_stop   = turn_off;
    result.join_request = 1'b0;
    result.message      = lfs_pkg::MSG_NONE;

    // Link state machine.
    case (mid.fsm_mode)
      lfs_pkg::MODE_CONNECTING: begin
        if (link_ok) begin
          state_next.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (mid.phase_on && (wait_elapsed > cfg.connect_wait_ms)) begin
          state_next.grace_start_time = step.now_ms;
          state_next.fsm_mode         = lfs_pkg::MODE_GRACE;
        end
      end
      lfs_pkg::MODE_ACTIVE: begin
        if (!link_ok && mid.phase_on) begin
          state_next.grace_start_time = step.now_ms;
          state_next.fsm_mode         = lfs_pkg::MODE_GRACE;
        end
      end
      lfs_pkg::MODE_GRACE: begin
        if (link_ok) begin
          state_next.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (!mid.phase_on) begin
          state_next.fsm_mode = lfs_pkg::MODE_CONNECTING;
        end else if (grace_elapsed > cfg.grace_time_ms) begin
          // Rate-limited join attempt; its outcome is sampled in the same step.
          if (!mid.joined && (join_elapsed > cfg.join_spacing_ms)) begin
            result.join_request       = 1'b1;
            state_next.last_join_time = step.now_ms;
            joined_now                = step.join_ok;
          end
          state_next.joined = joined_now;
          if (joined_now) begin
            result.message            = lfs_pkg::MSG_MISSING;
            state_next.last_send_time = step.now_ms;
            state_next.fsm_mode       = lfs_pkg::MODE_BACKUP;
          end
        end
      end
      default: begin
        // Backup: report return, hold while the radio is off, else repeat.
        if (link_ok) begin
          if (mid.joined) begin
            result.message = lfs_pkg::MSG_RETURNED;
          end
          state_next.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (mid.phase_on && (send_elapsed > cfg.send_interval_ms)) begin
          result.message            = lfs_pkg::MSG_MISSING;
          state_next.last_send_time = step.now_ms;
        end
      end
    endcase

    result.mode     = state_next.fsm_mode;
    result.radio_on = state_next.phase_on;
  end

endmodule

/* hw/rtl/link_failover_supervisor_core.sv */
// ----------------------------------------------------------------------------
// Link failover supervisor core
// Runs the short-range radio duty cycle and the connecting / active / grace /
// backup state machine, one supervisory step per request.
//
//   Channel  Signals                                   Carries
//   step     step_valid, step_ready, step_data         now_ms, link, join outcome
//   result   result_valid, result_ready, result_data   mode, pulses, message
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  timing register write
//
// A step request is registered in the input register, evaluated combinationally
// against the stored state and written to the result register, which offers it;
// one request per cycle is sustained while results are taken.
// The state update and the result load happen on the same edge, so the next
// request sees the updated state without extra delay.
// A stalled result holds the result register; one further request waits in
// the input register and step_ready drops until the result is taken.
// Synchronous reset clears the state and both valids and reloads timing defaults.
// Configuration writes are always taken (cfg_ready high); indexes above five
// are ignored.
// ----------------------------------------------------------------------------
module link_failover_supervisor_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step_valid,
  output logic                                 step_ready,
  input  lfs_pkg::step_t                       step_data,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output lfs_pkg::result_t                     result_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);

  logic             stage_valid;
  lfs_pkg::step_t   stage;
  logic             advance;
  lfs_pkg::cfg_t    cfg;
  lfs_pkg::state_t  state;
  lfs_pkg::state_t  state_next;
  lfs_pkg::result_t result_next;

  // Handshake: a staged request moves on when the result register is free.
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign step_ready = !stage_valid || advance;
  assign cfg_ready  = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (step_ready) begin
      stage_valid <= step_valid;
    end
    if (step_valid && step_ready) begin
      stage <= step_data;
    end
  end

  // Timing configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_period_ms    <= lfs_pkg::OFF_PERIOD_RST;
      cfg.on_period_ms     <= lfs_pkg::ON_PERIOD_RST;
      cfg.connect_wait_ms  <= lfs_pkg::CONNECT_WAIT_RST;
      cfg.grace_time_ms    <= lfs_pkg::GRACE_TIMEOUT_RST;
      cfg.join_spacing_ms  <= lfs_pkg::JOIN_RETRY_RST;
      cfg.send_interval_ms <= lfs_pkg::SEND_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfs_pkg::CFG_OFF_PERIOD:    cfg.off_period_ms    <= cfg_data;
        lfs_pkg::CFG_ON_PERIOD:     cfg.on_period_ms     <= cfg_data;
        lfs_pkg::CFG_CONNECT_WAIT:  cfg.connect_wait_ms  <= cfg_data;
        lfs_pkg::CFG_GRACE_TIMEOUT: cfg.grace_time_ms    <= cfg_data;
        lfs_pkg::CFG_JOIN_RETRY:    cfg.join_spacing_ms  <= cfg_data;
        lfs_pkg::CFG_SEND_INTERVAL: cfg.send_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step evaluation.
  lfs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .step       (stage),
    .state_next (state_next),
    .result     (result_next)
  );

  // Supervisor state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.fsm_mode         <= lfs_pkg::MODE_CONNECTING;
      state.phase_on         <= 1'b0;
      state.phase_start_time <= 32'd0;
      state.wait_start_time  <= 32'd0;
      state.grace_start_time <= 32'd0;
      state.last_send_time   <= 32'd0;
      state.last_join_time   <= 32'd0;
      state.joined           <= 1'b0;
      result_valid           <= 1'b0;
    end else begin
      if (advance) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (advance) begin
      result_data <= result_next;
    end
  end

  // Once joined, the supervisor stays joined until reset.
  a_joined_sticky: assert property (@(posedge clk) disable iff (rst)
    state.joined |=> state.joined)
    else $error("joined flag cleared without reset");

  // A step cannot both start and stop the radio, and the level follows the pulse.
  a_duty_pulses: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_data.radio_start && result_data.radio_stop) &&
      (!result_data.radio_start || result_data.radio_on) &&
      (!result_data.radio_stop || !result_data.radio_on))
    else $error("inconsistent duty cycle pulses");

  // A returned message is only sent when going back to active.
  a_returned_active: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_data.message == lfs_pkg::MSG_RETURNED)) |->
      (result_data.mode == lfs_pkg::MODE_ACTIVE))
    else $error("returned message outside active mode");

  // A join attempt happens only from grace, ending in grace or backup.
  a_join_mode: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.join_request) |->
      ((result_data.mode == lfs_pkg::MODE_GRACE) ||
       (result_data.mode == lfs_pkg::MODE_BACKUP)))
    else $error("join request outside grace or backup");

  // A missing message is only sent in backup mode.
  a_missing_backup: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_data.message == lfs_pkg::MSG_MISSING)) |->
      (result_data.mode == lfs_pkg::MODE_BACKUP))
    else $error("missing message outside backup mode");

endmodule

/* tb/link_failover_supervisor_core_test.sv */
// ----------------------------------------------------------------------------
// Link failover supervisor core testbench
// Sends supervisory step requests to the core through a bursty driver and takes
// the results through a monitor that stalls on a changing ready pattern. Every
// accepted step is fed to a behavioural predictor of the duty cycle and the
// connecting / active / grace / backup machine. Each result is then checked
// field by field against the oldest prediction. The timing registers are
// rewritten between phases: a short directed set, zero and full-range periods,
// and random settings.
// ----------------------------------------------------------------------------
module link_failover_supervisor_core_test;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned STEPS_PER_PHASE = 100;

  // Indexes past the last timing register; writes to them must be ignored.
  localparam logic [lfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [lfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic step_valid = 1'b0;
  logic step_ready;
  lfs_pkg::step_t step_data = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  lfs_pkg::result_t result_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the timing registers and the supervisor state.
  lfs_pkg::cfg_t timing;
  lfs_pkg::state_t sup_state;

  lfs_pkg::step_t pending_steps[$];
  lfs_pkg::result_t expected_results[$];
  lfs_pkg::result_t predicted;
  lfs_pkg::result_t want;

  int unsigned steps_queued = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;
  int unsigned joins_tried = 0;
  int unsigned missing_sent = 0;
  int unsigned returned_sent = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pattern;
  logic [3:0] stall_pos;

  logic [31:0] clock_ms;
  logic link_level;

  link_failover_supervisor_core DUT (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .step_data    (step_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Time elapsed since a stored timestamp, wrapping modulo 2^32.
  function automatic logic [31:0] since(input logic [31:0] stamp, input logic [31:0] now);
    return now - stamp;
  endfunction

  // Applies one step to the predicted state and returns the expected result.
  function automatic lfs_pkg::result_t advance_supervisor(input lfs_pkg::step_t s);
    lfs_pkg::result_t r;
    logic up;
    r = '0;
    r.message = lfs_pkg::MSG_NONE;

    // The duty cycle moves first; any phase change restarts connecting.
    if (!sup_state.phase_on &&
        since(sup_state.phase_start_time, s.now_ms) >= timing.off_period_ms) begin
      sup_state.phase_on = 1'b1;
      sup_state.phase_start_time = s.now_ms;
      sup_state.wait_start_time = s.now_ms;
      sup_state.fsm_mode = lfs_pkg::MODE_CONNECTING;
      r.radio_start = 1'b1;
    end else if (sup_state.phase_on &&
                 since(sup_state.phase_start_time, s.now_ms) >= timing.on_period_ms) begin
      sup_state.phase_on = 1'b0;
      sup_state.phase_start_time = s.now_ms;
      sup_state.fsm_mode = lfs_pkg::MODE_CONNECTING;
      r.radio_stop = 1'b1;
    end

    // The gateway link only counts while the radio is on.
    up = s.gateway_connected && sup_state.phase_on;

    case (sup_state.fsm_mode)
      lfs_pkg::MODE_CONNECTING: begin
        if (up) begin
          sup_state.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (sup_state.phase_on &&
                     since(sup_state.wait_start_time, s.now_ms) > timing.connect_wait_ms) begin
          sup_state.grace_start_time = s.now_ms;
          sup_state.fsm_mode = lfs_pkg::MODE_GRACE;
        end
      end
      lfs_pkg::MODE_ACTIVE: begin
        if (!up && sup_state.phase_on) begin
          sup_state.grace_start_time = s.now_ms;
          sup_state.fsm_mode = lfs_pkg::MODE_GRACE;
        end
      end
      lfs_pkg::MODE_GRACE: begin
        if (up) begin
          sup_state.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (!sup_state.phase_on) begin
          sup_state.fsm_mode = lfs_pkg::MODE_CONNECTING;
        end else if (since(sup_state.grace_start_time, s.now_ms) > timing.grace_time_ms) begin
          // Join attempts are rate limited and stop once one is accepted.
          if (!sup_state.joined &&
              since(sup_state.last_join_time, s.now_ms) > timing.join_spacing_ms) begin
            r.join_request = 1'b1;
            sup_state.last_join_time = s.now_ms;
            sup_state.joined = s.join_ok;
          end
          if (sup_state.joined) begin
            r.message = lfs_pkg::MSG_MISSING;
            sup_state.last_send_time = s.now_ms;
            sup_state.fsm_mode = lfs_pkg::MODE_BACKUP;
          end
        end
      end
      default: begin
        if (up) begin
          if (sup_state.joined) begin
            r.message = lfs_pkg::MSG_RETURNED;
          end
          sup_state.fsm_mode = lfs_pkg::MODE_ACTIVE;
        end else if (sup_state.phase_on &&
                     since(sup_state.last_send_time, s.now_ms) > timing.send_interval_ms) begin
          r.message = lfs_pkg::MSG_MISSING;
          sup_state.last_send_time = s.now_ms;
        end
      end
    endcase

    r.mode = sup_state.fsm_mode;
    r.radio_on = sup_state.phase_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("Result field %s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 500);
    endcase
  endfunction

  task automatic queue_step(input logic [31:0] now, input logic link, input logic jok);
    lfs_pkg::step_t s;
    s.now_ms = now;
    s.gateway_connected = link;
    s.join_ok = jok;
    pending_steps.push_back(s);
    steps_queued++;
  endtask

  // Mostly steady time and link runs, with the odd large jump in time.
  task automatic queue_random_steps(input int unsigned count, input int unsigned stride);
    logic [31:0] delta;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: delta = $urandom();
        1, 2, 3: delta = $urandom_range(0, 2);
        default: delta = $urandom_range(1, stride);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        link_level = ~link_level;
      end
      clock_ms = clock_ms + delta;
      queue_step(clock_ms, link_level, $urandom_range(0, 3) == 0);
    end
  endtask

  // One register write on the configuration channel; the predictor follows it.
  task automatic write_reg(input logic [lfs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lfs_pkg::CFG_OFF_PERIOD:    timing.off_period_ms = val;
      lfs_pkg::CFG_ON_PERIOD:     timing.on_period_ms = val;
      lfs_pkg::CFG_CONNECT_WAIT:  timing.connect_wait_ms = val;
      lfs_pkg::CFG_GRACE_TIMEOUT: timing.grace_time_ms = val;
      lfs_pkg::CFG_JOIN_RETRY:    timing.join_spacing_ms = val;
      lfs_pkg::CFG_SEND_INTERVAL: timing.send_interval_ms = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_timing(input logic [31:0] off_ms, input logic [31:0] on_ms,
                              input logic [31:0] wait_ms, input logic [31:0] grace_ms,
                              input logic [31:0] retry_ms, input logic [31:0] send_ms);
    write_reg(lfs_pkg::CFG_OFF_PERIOD, off_ms);
    write_reg(lfs_pkg::CFG_ON_PERIOD, on_ms);
    write_reg(lfs_pkg::CFG_CONNECT_WAIT, wait_ms);
    write_reg(lfs_pkg::CFG_GRACE_TIMEOUT, grace_ms);
    write_reg(lfs_pkg::CFG_JOIN_RETRY, retry_ms);
    write_reg(lfs_pkg::CFG_SEND_INTERVAL, send_ms);
    settings_used++;
  endtask

  // Waits until every queued request has produced its checked result.
  task automatic settle();
    while (results_checked < steps_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: presents queued requests in bursts with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (step_valid && step_ready) begin
        predicted = advance_supervisor(step_data);
        expected_results.push_back(predicted);
        if (predicted.join_request) joins_tried++;
        if (predicted.message == lfs_pkg::MSG_MISSING) missing_sent++;
        if (predicted.message == lfs_pkg::MSG_RETURNED) returned_sent++;
      end
      if (!step_valid || step_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          step_valid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          step_data <= pending_steps.pop_front();
          step_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result and stalls on a pattern redrawn whenever the
  // four-bit position wraps. Bit zero is forced high so no stall outlasts the pattern.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_pos = '0;
      stall_pattern = '1;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("Result %h arrived with no step request outstanding", result_data);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("mode", 32'(want.mode), 32'(result_data.mode));
          check_field("radio_on", 32'(want.radio_on), 32'(result_data.radio_on));
          check_field("radio_start", 32'(want.radio_start), 32'(result_data.radio_start));
          check_field("radio_stop", 32'(want.radio_stop), 32'(result_data.radio_stop));
          check_field("join_request", 32'(want.join_request),
                      32'(result_data.join_request));
          check_field("message", 32'(want.message), 32'(result_data.message));
          results_checked++;
        end
      end
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom());
          2: stall_pattern = 16'($urandom() | $urandom());
          default: stall_pattern = 16'($urandom() & $urandom());
        endcase
        stall_pattern[0] = 1'b1;
      end
      result_ready <= stall_pattern[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d of %0d results checked",
               cycle_count, results_checked, steps_queued);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_ms;

    timing.off_period_ms = lfs_pkg::OFF_PERIOD_RST;
    timing.on_period_ms = lfs_pkg::ON_PERIOD_RST;
    timing.connect_wait_ms = lfs_pkg::CONNECT_WAIT_RST;
    timing.grace_time_ms = lfs_pkg::GRACE_TIMEOUT_RST;
    timing.join_spacing_ms = lfs_pkg::JOIN_RETRY_RST;
    timing.send_interval_ms = lfs_pkg::SEND_INTERVAL_RST;
    sup_state = '0;
    sup_state.fsm_mode = lfs_pkg::MODE_CONNECTING;
    link_level = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Short periods so that every mode is reached within a few steps. The
    // spare indexes are written afterwards and must leave the timing alone.
    write_timing(32'd100, 32'd1000, 32'd50, 32'd100, 32'd200, 32'd150);
    write_reg(CFG_SPARE_LO, 32'd1);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);

    queue_step(32'd0, 1'b0, 1'b0);           // radio still off
    queue_step(32'd100, 1'b1, 1'b1);         // radio on, link straight away
    queue_step(32'd120, 1'b0, 1'b1);         // link lost, grace starts
    queue_step(32'd130, 1'b1, 1'b0);         // link back within grace
    queue_step(32'd140, 1'b0, 1'b0);         // grace again
    queue_step(32'd241, 1'b0, 1'b0);         // grace expired, join refused
    queue_step(32'd300, 1'b0, 1'b1);         // retry spacing not yet met
    queue_step(32'd442, 1'b0, 1'b1);         // join accepted, backup entered
    queue_step(32'd500, 1'b0, 1'b0);         // send interval not yet met
    queue_step(32'd593, 1'b0, 1'b0);         // repeated missing message
    queue_step(32'd600, 1'b1, 1'b0);         // link back, returned message
    queue_step(32'd1100, 1'b1, 1'b0);        // on period over, radio off
    queue_step(32'd1150, 1'b1, 1'b0);        // link ignored while radio off
    queue_step(32'd1200, 1'b0, 1'b0);        // radio on, no gateway
    queue_step(32'd1251, 1'b0, 1'b0);        // connect wait expired
    queue_step(32'd1260, 1'b1, 1'b0);        // link from grace
    queue_step(32'hFFFF_FFF0, 1'b1, 1'b1);   // far ahead, radio off
    queue_step(32'h0000_0060, 1'b0, 1'b0);   // across the wrap, radio on
    queue_step(32'h0000_0060, 1'b1, 1'b0);   // same timestamp again
    settle();

    // Zero-length periods: the duty phase flips on every step.
    write_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    clock_ms = 32'h0000_0060;
    queue_random_steps(20, 3);
    settle();

    // Full-range periods: a phase change needs an elapsed time of all ones.
    write_timing('1, '1, '1, '1, '1, '1);
    edge_ms = sup_state.phase_start_time - 32'd1;
    queue_step(edge_ms, 1'b1, 1'b0);
    queue_step(edge_ms, 1'b0, 1'b1);
    queue_step(edge_ms - 32'd1, 1'b1, 1'b0);
    queue_step(edge_ms - 32'd1, 1'b1, 1'b1);
    queue_step(edge_ms - 32'd2, 1'b0, 1'b0);
    queue_step(edge_ms - 32'd3, 1'b1, 1'b0);
    settle();
    clock_ms = edge_ms - 32'd3;

    // Random phases, every fourth one with extreme register values.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 == 3) begin
        write_timing(pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme(), pick_extreme(), pick_extreme());
      end else begin
        write_timing($urandom_range(20, 400), $urandom_range(100, 3000),
                     $urandom_range(0, 150), $urandom_range(0, 300),
                     $urandom_range(0, 500), $urandom_range(0, 300));
      end
      if (p == 5) begin
        clock_ms = 32'hFFFF_FC00;
      end
      queue_random_steps(STEPS_PER_PHASE, $urandom_range(5, 60));
      settle();
    end

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end

    $display("Covered %0d steps under %0d timing settings, zero and full-range ones included.",
             steps_queued, settings_used);
    $display("Join attempts %0d, missing messages %0d, returned messages %0d.",
             joins_tried, missing_sent, returned_sent);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
